/* src/binary_sequence_autocorrelation_energy_assert.svh */
// assertion macros for the autocorrelation energy block
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef BINARY_SEQUENCE_AUTOCORRELATION_ENERGY_ASSERT_SVH
`define BINARY_SEQUENCE_AUTOCORRELATION_ENERGY_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property holds at every clock edge outside reset
`define BSAE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bsae assertion failed");

// consequent holds in the cycle after the antecedent
`define BSAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsae assertion failed");

`else

`define BSAE_ASSERT(label, clk, rst_n, prop)
`define BSAE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/bsae_pkg.sv */
// shared widths, constants and control type of the autocorrelation energy block
// no dependencies
package bsae_pkg;

    localparam int SEQ_W       = 64;
    localparam int LEN_W       = 7;
    localparam int CORR_W      = 8;
    localparam int SQ_W        = 16;
    localparam int ENERGY_W    = 17;
    localparam int MAX_LEN_DEF = 64;

    localparam logic [LEN_W-1:0]    LEN_RESET  = 7'd64;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = 17'd85344;

    // control from the sequencer to the accumulator
    typedef struct packed {
        logic clear;
        logic add;
    } t_acc_ctrl;

endpackage

/* src/bsae_corr.sv */
// one shift correlation per enabled cycle: masked xor popcount turned into C_k, registered
// depends on bsae_pkg
module bsae_corr (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic [bsae_pkg::SEQ_W-1:0]          i_seq,
    input  logic [bsae_pkg::SEQ_W-1:0]          i_shift,
    input  logic [bsae_pkg::SEQ_W-1:0]          i_mask,
    input  logic [bsae_pkg::LEN_W-1:0]          i_ovl,
    output logic signed [bsae_pkg::CORR_W-1:0]  o_corr,
    output logic                                o_corr_valid
);

    logic [bsae_pkg::SEQ_W-1:0]  n_diff;
    logic [bsae_pkg::LEN_W-1:0]  n_pop;
    logic [bsae_pkg::CORR_W-1:0] n_corr;
    logic [bsae_pkg::CORR_W-1:0] r_corr;
    logic                        r_corr_valid;

    // disagreeing pairs inside the overlap, then overlap minus twice that count
    always_comb begin
        n_diff = (i_seq ^ i_shift) & i_mask;
        n_pop  = bsae_pkg::LEN_W'($countones(n_diff));
        n_corr = bsae_pkg::CORR_W'(i_ovl) - bsae_pkg::CORR_W'({n_pop, 1'b0});
    end

    // correlation register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_corr <= n_corr;
        end
    end

    // valid flag follows the enable in the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corr_valid <= 1'b0;
        end else begin
            r_corr_valid <= i_en;
        end
    end

    assign o_corr       = $signed(r_corr);
    assign o_corr_valid = r_corr_valid;

endmodule

/* src/bsae_acc.sv */
// squares the registered correlation and adds it to the energy sum, or clears the sum
// depends on bsae_pkg
module bsae_acc (
    input  logic                                i_clk,
    input  bsae_pkg::t_acc_ctrl                 i_ctrl,
    input  logic signed [bsae_pkg::CORR_W-1:0]  i_corr,
    output logic [bsae_pkg::ENERGY_W-1:0]       o_acc
);

    logic signed [bsae_pkg::SQ_W-1:0] n_sq;
    logic [bsae_pkg::ENERGY_W-1:0]    r_acc;

    // square of the correlation, always non-negative
    always_comb begin
        n_sq = bsae_pkg::SQ_W'(i_corr) * bsae_pkg::SQ_W'(i_corr);
    end

    // energy sum
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (i_ctrl.add) begin
            r_acc <= r_acc + bsae_pkg::ENERGY_W'(unsigned'(n_sq));
        end
    end

    assign o_acc = r_acc;

endmodule

/* src/binary_sequence_autocorrelation_energy.sv */
// autocorrelation energy of a +1/-1 sequence: sequencer, output register, config
// depends on bsae_pkg, bsae_corr, bsae_acc and the assertion header
// one shift per cycle in the run state: an item of effective length two or more passes through the
// run, flush and done states, one below two goes straight to done; done loads the result into the output
// register once it is free or being emptied, and the next item is accepted only back in idle
// synchronous active-low reset clears control state and sets seq_length to 64
`include "binary_sequence_autocorrelation_energy_assert.svh"

module binary_sequence_autocorrelation_energy #(
    parameter int MAX_LEN = bsae_pkg::MAX_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bsae_pkg::LEN_W-1:0]      i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [bsae_pkg::SEQ_W-1:0]      i_seq_bits,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bsae_pkg::ENERGY_W-1:0]   o_energy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam logic [bsae_pkg::LEN_W-1:0] MAX_LEN_V = bsae_pkg::LEN_W'(MAX_LEN);
    localparam logic [bsae_pkg::LEN_W-1:0] FULL_LEN  = bsae_pkg::LEN_W'(bsae_pkg::SEQ_W);

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;
    logic [bsae_pkg::LEN_W-1:0]      r_seq_length;
    logic [bsae_pkg::SEQ_W-1:0]      r_seq;
    logic [bsae_pkg::SEQ_W-1:0]      r_shift;
    logic [bsae_pkg::SEQ_W-1:0]      r_mask;
    logic [bsae_pkg::LEN_W-1:0]      r_ovl;
    logic                            r_out_valid;
    logic [bsae_pkg::ENERGY_W-1:0]   r_energy;

    logic [bsae_pkg::LEN_W-1:0]      n_len;
    logic [bsae_pkg::SEQ_W-1:0]      n_lmask;
    logic [bsae_pkg::SEQ_W-1:0]      n_seq;
    logic                            n_accept;
    logic                            n_short;
    logic                            n_load_out;

    logic signed [bsae_pkg::CORR_W-1:0] w_corr;
    logic                               w_corr_valid;
    logic [bsae_pkg::ENERGY_W-1:0]      w_acc;
    bsae_pkg::t_acc_ctrl                w_acc_ctrl;

    // effective length and element mask of the incoming item
    always_comb begin
        n_len    = (r_seq_length > MAX_LEN_V) ? MAX_LEN_V : r_seq_length;
        n_lmask  = {bsae_pkg::SEQ_W{1'b1}} >> (FULL_LEN - n_len);
        n_seq    = i_seq_bits & n_lmask;
        n_accept = i_valid && o_ready;
        n_short  = (n_len < bsae_pkg::LEN_W'(2));
    end

    // output register loads in the done state when free or being emptied
    assign n_load_out = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (n_accept) begin
                    n_state = n_short ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                if (r_ovl == bsae_pkg::LEN_W'(1)) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: n_state = S_DONE;
            S_DONE: begin
                if (n_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_seq_length <= bsae_pkg::LEN_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_seq_length <= i_cfg_wdata;
            end
            if (n_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // shift line, overlap mask and overlap count, one shift per cycle in the run state
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_seq   <= n_seq;
            r_shift <= n_seq >> 1;
            r_mask  <= n_lmask >> 1;
            r_ovl   <= n_len - bsae_pkg::LEN_W'(1);
        end else if (r_state == S_RUN) begin
            r_shift <= r_shift >> 1;
            r_mask  <= r_mask >> 1;
            r_ovl   <= r_ovl - bsae_pkg::LEN_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (n_load_out) begin
            r_energy <= w_acc;
        end
    end

    bsae_corr u_corr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (r_state == S_RUN),
        .i_seq        (r_seq),
        .i_shift      (r_shift),
        .i_mask       (r_mask),
        .i_ovl        (r_ovl),
        .o_corr       (w_corr),
        .o_corr_valid (w_corr_valid)
    );

    // accumulator control: clear on a new item, add each finished correlation
    always_comb begin
        w_acc_ctrl.clear = n_accept;
        w_acc_ctrl.add   = w_corr_valid;
    end

    bsae_acc u_acc (
        .i_clk  (i_clk),
        .i_ctrl (w_acc_ctrl),
        .i_corr (w_corr),
        .o_acc  (w_acc)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_energy = r_energy;

    // checks
    `BSAE_ASSERT(a_ovl_nonzero, i_clk, i_rst_n, (r_state != S_RUN) || (r_ovl != '0))
    `BSAE_ASSERT(a_no_add_idle, i_clk, i_rst_n, (r_state != S_IDLE) || !w_corr_valid)
    `BSAE_ASSERT_NEXT(a_short_done, i_clk, i_rst_n, n_accept && n_short, r_state == S_DONE)
    `BSAE_ASSERT(a_energy_max, i_clk, i_rst_n, !r_out_valid || (r_energy <= bsae_pkg::ENERGY_MAX))

endmodule

/* test/tb_top.sv */
// testbench for binary_sequence_autocorrelation_energy: queue-fed driver, checking monitor
// predicts the energy of each accepted sequence; depends on bsae_pkg and the block's RTL
`timescale 1ns / 100ps

module tb_top;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 50;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [bsae_pkg::LEN_W-1:0]    i_cfg_wdata;
    logic                          i_valid;
    logic                          o_ready;
    logic [bsae_pkg::SEQ_W-1:0]    i_seq_bits;
    logic                          o_valid;
    logic                          i_ready;
    logic [bsae_pkg::ENERGY_W-1:0] o_energy;

    // sequences waiting to be sent, energies waiting to come back
    logic [bsae_pkg::SEQ_W-1:0]    pending_seqs[$];
    logic [bsae_pkg::ENERGY_W-1:0] energy_due[$];
    logic [bsae_pkg::ENERGY_W-1:0] energy_want;

    // predictor copy of the length register
    logic [bsae_pkg::LEN_W-1:0]    len_cfg;

    int snd_idle_pct;
    int rcv_idle_pct;
    int mismatches;
    int quiet_cycles;

    binary_sequence_autocorrelation_energy DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_seq_bits  (i_seq_bits),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_energy    (o_energy)
    );

    always #6 i_clk = ~i_clk;

    // sum of squared aperiodic autocorrelations over shifts 1 .. L-1
    function automatic logic [bsae_pkg::ENERGY_W-1:0] seq_energy(
        input logic [bsae_pkg::SEQ_W-1:0] seq,
        input logic [bsae_pkg::LEN_W-1:0] cfg);
        int n;
        int corr;
        int total;
        logic [bsae_pkg::SEQ_W-1:0] s;
        logic [bsae_pkg::SEQ_W-1:0] diff;
        n = (cfg > bsae_pkg::MAX_LEN_DEF) ? bsae_pkg::MAX_LEN_DEF : int'(cfg);
        s = (n >= bsae_pkg::SEQ_W) ? seq : (seq & ((64'd1 << n) - 64'd1));
        total = 0;
        for (int k = 1; k < n; k++) begin
            diff = (s ^ (s >> k)) & ((64'd1 << (n - k)) - 64'd1);
            corr = (n - k) - 2 * $countones(diff);
            total += corr * corr;
        end
        return total[bsae_pkg::ENERGY_W-1:0];
    endfunction

    // random sequence: plain, near-constant, sparse or dense
    function automatic logic [bsae_pkg::SEQ_W-1:0] rand_seq();
        logic [bsae_pkg::SEQ_W-1:0] a;
        logic [bsae_pkg::SEQ_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return a;
            1: return {bsae_pkg::SEQ_W{a[0]}} ^ (64'd1 << b[5:0]) ^ (64'd1 << b[13:8]);
            2: return a & b & {$urandom, $urandom};
            default: return a | b | {$urandom, $urandom};
        endcase
    endfunction

    // driver: present queued sequences, hold each until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                energy_due.push_back(seq_energy(i_seq_bits, len_cfg));
            if (!i_valid || o_ready) begin
                if (pending_seqs.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                    i_valid    <= 1'b1;
                    i_seq_bits <= pending_seqs.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each accepted energy with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (energy_due.size() == 0) begin
                $error("energy: expected nothing, actual %0d", o_energy);
                mismatches++;
            end else begin
                energy_want = energy_due.pop_front();
                if (o_energy !== energy_want) begin
                    $error("energy: expected %0d, actual %0d", energy_want, o_energy);
                    mismatches++;
                end
            end
        end
        i_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // watchdog on cycles with no handshake and no register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** binary_sequence_autocorrelation_energy: FAILED **");
            $finish;
        end
    end

    // wait until every queued item is sent and every energy has come back
    task automatic drain();
        while (pending_seqs.size() != 0 || i_valid || energy_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // length register write, only while the block is idle
    task automatic set_length(input logic [bsae_pkg::LEN_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        len_cfg      = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // stimulus and end of run
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_valid      = 1'b0;
        i_seq_bits   = '0;
        i_ready      = 1'b0;
        len_cfg      = bsae_pkg::LEN_RESET;
        snd_idle_pct = 19;
        rcv_idle_pct = 48;
        mismatches   = 0;
        quiet_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // length from reset: constant, alternating, single-bit and one mixed sequence
        pending_seqs = '{64'h0, '1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                         64'h1, 64'h8000_0000_0000_0000, 64'h0123_4567_89AB_CDEF};
        drain();

        // length two, all four pairs with junk above
        set_length(7'd2);
        pending_seqs = '{64'hFFFF_FFFF_FFFF_FFFC, 64'h0000_0000_0000_0001,
                         64'hA5A5_A5A5_A5A5_A5A6, 64'h5A5A_5A5A_5A5A_5A5B};
        drain();

        // lengths below two give zero energy
        set_length(7'd0);
        pending_seqs = '{'1, 64'h0};
        drain();
        set_length(7'd1);
        pending_seqs = '{rand_seq(), rand_seq()};
        drain();

        // lengths above the maximum saturate
        set_length(7'd127);
        pending_seqs = '{'1, rand_seq()};
        drain();
        set_length(7'd65);
        pending_seqs = '{64'h0, rand_seq()};
        drain();

        set_length(7'd3);
        pending_seqs = '{64'h5, 64'h3, rand_seq()};
        drain();

        // random phases over the three idling modes
        for (int mode = 0; mode < 3; mode++) begin
            snd_idle_pct = (mode == 0) ? 19 : (mode == 1) ? 48 : 0;
            rcv_idle_pct = (mode == 0) ? 48 : (mode == 1) ? 19 : 0;
            for (int ph = 0; ph < 5; ph++) begin
                case (ph)
                    0: set_length(7'd64);
                    1: set_length(7'd2);
                    2: set_length(bsae_pkg::LEN_W'($urandom_range(2, 64)));
                    3: set_length(bsae_pkg::LEN_W'($urandom_range(0, 127)));
                    default: set_length(bsae_pkg::LEN_W'($urandom_range(2, 16)));
                endcase
                for (int i = 0; i < PHASE_ITEMS; i++)
                    pending_seqs.push_back(rand_seq());
                drain();
            end
        end

        repeat (80) @(posedge i_clk);
        if (mismatches == 0 && energy_due.size() == 0) begin
            $display("** binary_sequence_autocorrelation_energy: PASSED **");
        end else begin
            if (energy_due.size() != 0)
                $error("energy: %0d expected results never arrived", energy_due.size());
            $display("** binary_sequence_autocorrelation_energy: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/bsae_pkg.sv
src/bsae_corr.sv
src/bsae_acc.sv
src/binary_sequence_autocorrelation_energy.sv
test/tb_top.sv
